[rtl/core/ntc_pkg.sv]
// shared widths, constants and codes of the ntc temperature converter
package ntc_pkg;

    localparam int DEF_ADC_BITS = 12;

    // register field widths
    localparam int RF_W   = 29;
    localparam int RW_W   = 20;
    localparam int BETA_W = 14;
    localparam int R0_W   = 29;
    localparam int T0_W   = 16;

    // apb port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_FIXED_RES = 3'd0;
    localparam logic [IDX_W-1:0] REG_WIRE_RES  = 3'd1;
    localparam logic [IDX_W-1:0] REG_BETA      = 3'd2;
    localparam logic [IDX_W-1:0] REG_NOM_RES   = 3'd3;
    localparam logic [IDX_W-1:0] REG_NOM_TEMP  = 3'd4;

    localparam logic [RF_W-1:0]   RST_FIXED_RES = 29'd1000000;
    localparam logic [RW_W-1:0]   RST_WIRE_RES  = 20'd0;
    localparam logic [BETA_W-1:0] RST_BETA      = 14'd3950;
    localparam logic [R0_W-1:0]   RST_NOM_RES   = 29'd1000000;
    localparam logic [T0_W-1:0]   RST_NOM_TEMP  = 16'd29815;

    // result fields
    localparam int TEMP_W   = 16;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT     = 2'd2;

    localparam logic [TEMP_W-1:0] TEMP_MAX = 16'h7fff;

    // resistance products are adc bits plus this many bits, sign included
    localparam int PROD_EXTRA = RF_W + 1;

    // log2 unit: q30 fraction, encode stage + normalize stage + one stage per bit
    localparam int FRAC_BITS = 30;
    localparam int LOG_LAT   = FRAC_BITS + 2;

    // ln(2) in q24, product shifted down to q20
    localparam int              LN2_W    = 24;
    localparam logic [LN2_W-1:0] LN2_Q24 = 24'd11629080;
    localparam int              LN_SHIFT = 34;

    // 100*beta, numerator 100*beta*t0 and dividend width
    localparam int B100_W     = BETA_W + 7;
    localparam int NQ_W       = B100_W + T0_W;
    localparam int BETA_SHIFT = 20;
    localparam int DD_W       = NQ_W + BETA_SHIFT + 1;

    localparam int ZERO_C_CENTIK = 27315;
    localparam int SAT_Q         = 32767 + ZERO_C_CENTIK;

    // power of two
    localparam int QUEUE_DEPTH = 4;

endpackage

[rtl/core/ntc_front.sv]
// front end: takes a code, forms the thermistor resistance ratio and flags bad ones
module ntc_front
    import ntc_pkg::*;
#(
    parameter int ADC_BITS = DEF_ADC_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            take,
    input  logic [ADC_BITS-1:0]             adc_code,
    input  logic [RF_W-1:0]                 fixed_res,
    input  logic [RW_W-1:0]                 wire_res,
    input  logic [R0_W-1:0]                 nom_res,
    output logic                            push,
    output logic [ADC_BITS+PROD_EXTRA-1:0]  num,
    output logic [ADC_BITS+PROD_EXTRA-1:0]  dref,
    output logic                            inv
);

    localparam int X_W  = ADC_BITS + PROD_EXTRA;
    localparam int SP_W = ADC_BITS + 1;
    localparam int AR_W = ADC_BITS + RF_W;
    localparam int WS_W = SP_W + RW_W;

    logic            v_reg;
    logic [AR_W-1:0] a_rf_reg;
    logic [WS_W-1:0] rw_sp_reg;
    logic [X_W-1:0]  dref_reg;

    logic [SP_W-1:0]       span;
    logic signed [X_W-1:0] num_s;

    // code-to-full-scale span
    assign span = {1'b1, {ADC_BITS{1'b0}}} - {1'b0, adc_code};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        a_rf_reg  <= AR_W'(adc_code) * AR_W'(fixed_res);
        rw_sp_reg <= WS_W'(span) * WS_W'(wire_res);
        dref_reg  <= X_W'(span) * X_W'(nom_res);
    end

    // a*rf - 2*rw*span
    assign num_s = $signed({1'b0, a_rf_reg}) - $signed(X_W'({rw_sp_reg, 1'b0}));

    assign push = v_reg;
    assign num  = num_s;
    assign dref = dref_reg;
    assign inv  = num_s[X_W-1] | (num_s == '0) | (dref_reg == '0);

endmodule

[rtl/core/ntc_queue.sv]
// small fifo between front and back end
module ntc_queue
    import ntc_pkg::*;
#(
    parameter int W     = 2 * (DEF_ADC_BITS + PROD_EXTRA) + 1,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head,
    output logic         empty,
    output logic         nearly_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign count_next = count_reg + CNT_W'(push) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head        = mem_reg[rd_ptr_reg];
    assign empty       = (count_reg == '0);
    // leaves room for the item sitting in the front stage
    assign nearly_full = (count_reg >= CNT_W'(DEPTH - 2));

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != CNT_W'(DEPTH))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count mismatch");

endmodule

[rtl/core/ntc_log2.sv]
// pipelined log2 in q30: leading-one encode, normalize, one squaring per fraction bit
module ntc_log2
    import ntc_pkg::*;
#(
    parameter int X_W = DEF_ADC_BITS + PROD_EXTRA
)
(
    input  logic                          clk,
    input  logic [X_W-1:0]                x,
    output logic [$clog2(X_W)+FRAC_BITS-1:0] l2
);

    localparam int P_W = $clog2(X_W);
    localparam int M_W = FRAC_BITS + 1;

    function automatic logic [P_W-1:0] msb_pos(input logic [X_W-1:0] v);
        logic [P_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < X_W; i++)
        begin
            if (v[i])
            begin
                pos = P_W'(i);
            end
        end
        return pos;
    endfunction

    logic [X_W-1:0]       x_reg;
    logic [P_W-1:0]       p0_reg;
    logic [M_W-1:0]       m_reg [FRAC_BITS+1];
    logic [P_W-1:0]       p_reg [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] f_reg [FRAC_BITS+1];

    logic [P_W-1:0] sh;
    logic [X_W-1:0] norm;

    always_ff @(posedge clk)
    begin
        x_reg  <= x;
        p0_reg <= msb_pos(x);
    end

    // leading one to the top, keep 31 bits (truncating)
    assign sh   = P_W'(X_W - 1) - p0_reg;
    assign norm = x_reg << sh;

    always_ff @(posedge clk)
    begin
        m_reg[0] <= norm[X_W-1 -: M_W];
        p_reg[0] <= p0_reg;
        f_reg[0] <= '0;
    end

    for (genvar j = 0; j < FRAC_BITS; j++)
    begin : g_sq
        logic [2*M_W-1:0]     sq_next;
        logic [M_W:0]         t_next;
        logic [M_W-1:0]       m_next;
        logic [FRAC_BITS-1:0] f_next;

        always_comb
        begin
            sq_next = (2*M_W)'(m_reg[j]) * (2*M_W)'(m_reg[j]);
            t_next  = sq_next[2*M_W-1:FRAC_BITS];
            f_next  = f_reg[j];
            if (t_next[M_W])
            begin
                m_next                  = t_next[M_W:1];
                f_next[FRAC_BITS-1-j]   = 1'b1;
            end
            else
            begin
                m_next = t_next[M_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            m_reg[j+1] <= m_next;
            p_reg[j+1] <= p_reg[j];
            f_reg[j+1] <= f_next;
        end
    end

    assign l2 = {p_reg[FRAC_BITS], f_reg[FRAC_BITS]};

endmodule

[rtl/core/ntc_div.sv]
// pipelined restoring divider, one quotient bit per stage
module ntc_div
    import ntc_pkg::*;
#(
    parameter int DV_W = 44,
    parameter int DQ_W = DD_W
)
(
    input  logic            clk,
    input  logic [DQ_W-1:0] dividend,
    input  logic [DV_W-1:0] divisor,
    output logic [DQ_W-1:0] quotient
);

    logic [DV_W-1:0] rem_reg [DQ_W+1];
    logic [DQ_W-1:0] qd_reg  [DQ_W+1];
    logic [DV_W-1:0] d_reg   [DQ_W+1];

    assign rem_reg[0] = '0;
    assign qd_reg[0]  = dividend;
    assign d_reg[0]   = divisor;

    for (genvar j = 0; j < DQ_W; j++)
    begin : g_step
        logic [DV_W:0] r_next;
        logic [DV_W:0] diff_next;
        logic          ge_next;

        always_comb
        begin
            r_next    = {rem_reg[j], qd_reg[j][DQ_W-1]};
            diff_next = r_next - {1'b0, d_reg[j]};
            ge_next   = (r_next >= {1'b0, d_reg[j]});
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1] <= ge_next ? diff_next[DV_W-1:0] : r_next[DV_W-1:0];
            qd_reg[j+1]  <= {qd_reg[j][DQ_W-2:0], ge_next};
            d_reg[j+1]   <= d_reg[j];
        end
    end

    assign quotient = qd_reg[DQ_W];

endmodule

[rtl/core/ntc_back.sv]
// back end: log ratio, beta equation, division and saturation
module ntc_back
    import ntc_pkg::*;
#(
    parameter int ADC_BITS = DEF_ADC_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  logic [ADC_BITS+PROD_EXTRA-1:0] q_num,
    input  logic [ADC_BITS+PROD_EXTRA-1:0] q_dref,
    input  logic                           q_inv,
    input  logic [BETA_W-1:0]              beta,
    input  logic [T0_W-1:0]                t0,
    output logic                           pop,
    output logic                           done,
    output logic signed [TEMP_W-1:0]       temp,
    output logic [STATUS_W-1:0]            status
);

    localparam int X_W   = ADC_BITS + PROD_EXTRA;
    localparam int P_W   = $clog2(X_W);
    localparam int L_W   = P_W + FRAC_BITS;
    localparam int PR_W  = L_W + LN2_W;
    localparam int LM_W  = PR_W - LN_SHIFT;
    localparam int LQ_W  = LM_W + 1;
    localparam int LT_W  = LQ_W + T0_W + 1;
    localparam int DN_W  = LT_W + 1;
    localparam int DV_W  = DN_W - 1;

    // stage 0: queue head
    logic           v0_reg;
    logic           inv0_reg;
    logic [X_W-1:0] xn_reg;
    logic [X_W-1:0] xd_reg;

    logic [L_W-1:0] l2n;
    logic [L_W-1:0] l2d;

    logic [LOG_LAT-1:0] vlog_reg;
    logic [LOG_LAT-1:0] invlog_reg;

    // stage 1..5
    logic                   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                   inv1_reg, inv2_reg, inv3_reg, inv4_reg, inv5_reg;
    logic                   neg1_reg, neg2_reg;
    logic [L_W-1:0]         mag1_reg;
    logic [PR_W-1:0]        prod2_reg;
    logic [B100_W-1:0]      b100_2_reg, b100_3_reg;
    logic signed [LT_W-1:0] lt3_reg;
    logic [NQ_W-1:0]        nq3_reg, nq4_reg;
    logic signed [DN_W-1:0] dn4_reg;
    logic [DD_W-1:0]        dividend5_reg;
    logic [DV_W-1:0]        divisor5_reg;

    logic [DD_W-1:0] quot;
    logic [DD_W-1:0] vdiv_reg;
    logic [DD_W-1:0] invdiv_reg;

    logic                   done_reg;
    logic [TEMP_W-1:0]      temp_reg;
    logic [STATUS_W-1:0]    status_reg;

    logic [L_W:0]           diff_next;
    logic [L_W:0]           ndiff_next;
    logic [LM_W-1:0]        lm_next;
    logic signed [LQ_W-1:0] lq_next;
    logic signed [T0_W:0]   t0s;
    logic signed [DN_W-1:0] dn_next;
    logic                   bad_next;
    logic [TEMP_W:0]        tmp_next;

    assign pop = !q_empty;

    always_ff @(posedge clk)
    begin
        inv0_reg <= q_inv;
        // invalid items run with a harmless argument
        xn_reg   <= q_inv ? X_W'(1) : q_num;
        xd_reg   <= q_inv ? X_W'(1) : q_dref;
    end

    ntc_log2 #(.X_W(X_W)) u_log_num
    (
        .clk (clk),
        .x   (xn_reg),
        .l2  (l2n)
    );

    ntc_log2 #(.X_W(X_W)) u_log_den
    (
        .clk (clk),
        .x   (xd_reg),
        .l2  (l2d)
    );

    always_comb
    begin
        diff_next  = {1'b0, l2n} - {1'b0, l2d};
        ndiff_next = -diff_next;
        lm_next    = prod2_reg[PR_W-1:LN_SHIFT];
        lq_next    = neg2_reg ? -$signed({1'b0, lm_next}) : $signed({1'b0, lm_next});
        t0s        = $signed({1'b0, t0});
        dn_next    = $signed(DN_W'(lt3_reg))
                   + $signed(DN_W'({b100_3_reg, {BETA_SHIFT{1'b0}}}));
        bad_next   = dn4_reg[DN_W-1] | (dn4_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        inv1_reg   <= invlog_reg[LOG_LAT-1];
        neg1_reg   <= diff_next[L_W];
        mag1_reg   <= diff_next[L_W] ? ndiff_next[L_W-1:0] : diff_next[L_W-1:0];

        inv2_reg   <= inv1_reg;
        neg2_reg   <= neg1_reg;
        prod2_reg  <= PR_W'(mag1_reg) * PR_W'(LN2_Q24);
        b100_2_reg <= B100_W'(beta) * B100_W'(7'd100);

        inv3_reg   <= inv2_reg;
        lt3_reg    <= LT_W'(lq_next) * LT_W'(t0s);
        nq3_reg    <= NQ_W'(b100_2_reg) * NQ_W'(t0);
        b100_3_reg <= b100_2_reg;

        inv4_reg   <= inv3_reg;
        dn4_reg    <= dn_next;
        nq4_reg    <= nq3_reg;

        inv5_reg      <= inv4_reg | bad_next;
        divisor5_reg  <= bad_next ? DV_W'(1) : dn4_reg[DV_W-1:0];
        dividend5_reg <= DD_W'({nq4_reg, {BETA_SHIFT{1'b0}}})
                       + DD_W'(dn4_reg[DV_W-1:1]);

        invlog_reg <= {invlog_reg[LOG_LAT-2:0], inv0_reg};
        invdiv_reg <= {invdiv_reg[DD_W-2:0], inv5_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            vlog_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            vdiv_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= pop;
            vlog_reg <= {vlog_reg[LOG_LAT-2:0], v0_reg};
            v1_reg   <= vlog_reg[LOG_LAT-1];
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            vdiv_reg <= {vdiv_reg[DD_W-2:0], v5_reg};
            done_reg <= vdiv_reg[DD_W-1];
        end
    end

    ntc_div #(.DV_W(DV_W), .DQ_W(DD_W)) u_div
    (
        .clk      (clk),
        .dividend (dividend5_reg),
        .divisor  (divisor5_reg),
        .quotient (quot)
    );

    assign tmp_next = (TEMP_W+1)'(quot[TEMP_W-1:0]) - (TEMP_W+1)'(ZERO_C_CENTIK);

    always_ff @(posedge clk)
    begin
        if (invdiv_reg[DD_W-1])
        begin
            temp_reg   <= '0;
            status_reg <= ST_INVALID;
        end
        else if (quot > DD_W'(SAT_Q))
        begin
            temp_reg   <= TEMP_MAX;
            status_reg <= ST_SAT;
        end
        else
        begin
            temp_reg   <= tmp_next[TEMP_W-1:0];
            status_reg <= ST_OK;
        end
    end

    assign done   = done_reg;
    assign temp   = $signed(temp_reg);
    assign status = status_reg;

endmodule

[rtl/core/ntc_adc_code_to_temperature.sv]
// top level: ntc adc code to temperature converter with apb register port
//
// channel   | signals                                       | direction
// ----------+-----------------------------------------------+----------
// command   | start, busy, adc_code                         | in/out
// result    | done, temp_centi_celsius, status              | out
// config    | psel, penable, pwrite, paddr, pwdata, prdata, | in/out
//           | pready                                        |
//
// one code is taken per clock while busy is low; each code passes through
// the 30 squaring stages of the log2 units and the 58 one-bit stages of the
// divider, plus front, queue and equation stages
// reset clears the queue, the valid pipeline and the registers to defaults
// the result side has no stall: done marks each result for one cycle, and
// busy only rises if the front/back queue backs up
module ntc_adc_code_to_temperature
    import ntc_pkg::*;
#(
    parameter int ADC_BITS = DEF_ADC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // command
    input  logic                     start,
    output logic                     busy,
    input  logic [ADC_BITS-1:0]      adc_code,
    // result
    output logic                     done,
    output logic signed [TEMP_W-1:0] temp_centi_celsius,
    output logic [STATUS_W-1:0]      status,
    // apb
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    localparam int X_W = ADC_BITS + PROD_EXTRA;
    localparam int Q_W = 2 * X_W + 1;

    // configuration registers
    logic [RF_W-1:0]   fixed_res_reg;
    logic [RW_W-1:0]   wire_res_reg;
    logic [BETA_W-1:0] beta_reg;
    logic [R0_W-1:0]   nom_res_reg;
    logic [T0_W-1:0]   nom_temp_reg;

    logic             wr_en;
    logic [IDX_W-1:0] reg_idx;

    // front/back hand-off
    logic           take;
    logic           f_push;
    logic [X_W-1:0] f_num;
    logic [X_W-1:0] f_dref;
    logic           f_inv;
    logic [Q_W-1:0] q_head;
    logic           q_empty;
    logic           q_nearly_full;
    logic           b_pop;

    // apb: every transaction completes in its access cycle
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_res_reg <= RST_FIXED_RES;
            wire_res_reg  <= RST_WIRE_RES;
            beta_reg      <= RST_BETA;
            nom_res_reg   <= RST_NOM_RES;
            nom_temp_reg  <= RST_NOM_TEMP;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FIXED_RES: fixed_res_reg <= pwdata[RF_W-1:0];
                REG_WIRE_RES:  wire_res_reg  <= pwdata[RW_W-1:0];
                REG_BETA:      beta_reg      <= pwdata[BETA_W-1:0];
                REG_NOM_RES:   nom_res_reg   <= pwdata[R0_W-1:0];
                REG_NOM_TEMP:  nom_temp_reg  <= pwdata[T0_W-1:0];
                default:       ; // unmapped addresses ignore writes
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FIXED_RES: prdata = DATA_W'(fixed_res_reg);
            REG_WIRE_RES:  prdata = DATA_W'(wire_res_reg);
            REG_BETA:      prdata = DATA_W'(beta_reg);
            REG_NOM_RES:   prdata = DATA_W'(nom_res_reg);
            REG_NOM_TEMP:  prdata = DATA_W'(nom_temp_reg);
            default:       prdata = '0;
        endcase
    end

    // command transaction
    assign busy = q_nearly_full;
    assign take = start & ~busy;

    ntc_front #(.ADC_BITS(ADC_BITS)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .adc_code  (adc_code),
        .fixed_res (fixed_res_reg),
        .wire_res  (wire_res_reg),
        .nom_res   (nom_res_reg),
        .push      (f_push),
        .num       (f_num),
        .dref      (f_dref),
        .inv       (f_inv)
    );

    ntc_queue #(.W(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (f_push),
        .push_data   ({f_num, f_dref, f_inv}),
        .pop         (b_pop),
        .head        (q_head),
        .empty       (q_empty),
        .nearly_full (q_nearly_full)
    );

    // back end drains one entry per cycle while the queue is not empty
    ntc_back #(.ADC_BITS(ADC_BITS)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_num   (q_head[Q_W-1 -: X_W]),
        .q_dref  (q_head[X_W:1]),
        .q_inv   (q_head[0]),
        .beta    (beta_reg),
        .t0      (nom_temp_reg),
        .pop     (b_pop),
        .done    (done),
        .temp    (temp_centi_celsius),
        .status  (status)
    );

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_INVALID |-> temp_centi_celsius == '0)
        else $error("invalid result with nonzero temperature");

    a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_SAT |-> temp_centi_celsius == $signed(TEMP_MAX))
        else $error("saturated result off the rail");

    a_ok_above_zero_k: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_OK |-> temp_centi_celsius >= -16'sd27315)
        else $error("result below absolute zero");

endmodule

[bench/ntc_adc_code_to_temperature_tb.sv]
// testbench for the ntc adc code to temperature converter
`timescale 1ns / 1ps

module ntc_adc_code_to_temperature_tb;
    import ntc_pkg::*;

    localparam int CODE_W     = DEF_ADC_BITS;
    localparam int LATENCY    = 98;
    localparam int CYCLE_MAX  = 400000;
    localparam int RAND_ITEMS = 1750;
    localparam logic [63:0] ONE64 = 64'd1;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [CODE_W-1:0]        adc_code;
    logic                     done;
    logic signed [TEMP_W-1:0] temp_centi_celsius;
    logic [STATUS_W-1:0]      status;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    // one expected conversion result
    typedef struct packed {
        logic [TEMP_W-1:0]   temp;
        logic [STATUS_W-1:0] st;
    } reading_t;

    // one row of the directed table; has_known set where the result is typed in
    typedef struct {
        logic [CODE_W-1:0] code;
        bit                has_known;
        reading_t          known;
    } code_row_t;

    reading_t pending_readings[$];
    int       mismatch_count;
    int       cycle_count;
    int       send_idle_pct;

    // local copy of the register file
    logic [63:0] rf_q, rw_q, beta_q, r0_q, t0_q;

    ntc_adc_code_to_temperature dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .adc_code           (adc_code),
        .done               (done),
        .temp_centi_celsius (temp_centi_celsius),
        .status             (status),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // 4 ns period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // watchdog: fail if the run never completes
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // log2 in q30: leading-one position plus 30 rounds of truncating squaring
    function automatic logic [63:0] log2_fixed(input logic [63:0] x);
        int          msb;
        logic [63:0] mant;
        logic [63:0] frac;
        begin
            msb  = 0;
            frac = '0;
            while (msb < 63 && (x >> (msb + 1)) != 0)
                msb++;
            if (msb >= 30)
                mant = x >> (msb - 30);
            else
                mant = x << (30 - msb);
            for (int i = 29; i >= 0; i--)
            begin
                mant = (mant * mant) >> 30;
                if (mant >= (ONE64 << 31))
                begin
                    mant = mant >> 1;
                    frac = frac | (ONE64 << i);
                end
            end
            return (64'(msb) << 30) | frac;
        end
    endfunction

    // beta equation on the current register copy
    function automatic reading_t convert_code(input logic [CODE_W-1:0] code);
        logic [63:0]        a, span, dref, mag, lmag, nq, tck;
        logic signed [63:0] num, l2, lq, dn, t;
        reading_t           r;
        begin
            a    = 64'(code);
            span = (ONE64 << CODE_W) - a;
            num  = $signed(a * rf_q) - $signed(2 * rw_q * span);
            dref = span * r0_q;
            r.temp = '0;
            r.st   = ST_INVALID;
            if (num <= 0 || dref == 0)
                return r;
            l2   = $signed(log2_fixed(num)) - $signed(log2_fixed(dref));
            mag  = (l2 < 0) ? -l2 : l2;
            lmag = (mag * 64'(LN2_Q24)) >> LN_SHIFT;
            lq   = (l2 < 0) ? -$signed(lmag) : $signed(lmag);
            dn   = lq * $signed(t0_q) + $signed((100 * beta_q) << BETA_SHIFT);
            if (dn <= 0)
                return r;
            nq  = (100 * beta_q * t0_q) << BETA_SHIFT;
            tck = (nq + (dn >> 1)) / dn;
            t   = $signed(tck) - ZERO_C_CENTIK;
            r.st = ST_OK;
            if (t > 32767)
            begin
                t    = 32767;
                r.st = ST_SAT;
            end
            else if (t < -32768)
            begin
                t    = -32768;
                r.st = ST_SAT;
            end
            r.temp = t[TEMP_W-1:0];
            return r;
        end
    endfunction

    // apb write: setup then access, also updates the local register copy
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] value);
        begin
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_W'(idx) << 2;
            pwdata  <= value[DATA_W-1:0];
            @(negedge clk);
            penable <= 1'b1;
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            case (idx)
                REG_FIXED_RES: rf_q   = value & ((ONE64 << RF_W) - 1);
                REG_WIRE_RES:  rw_q   = value & ((ONE64 << RW_W) - 1);
                REG_BETA:      beta_q = value & ((ONE64 << BETA_W) - 1);
                REG_NOM_RES:   r0_q   = value & ((ONE64 << R0_W) - 1);
                REG_NOM_TEMP:  t0_q   = value & ((ONE64 << T0_W) - 1);
                default: ;
            endcase
        end
    endtask

    // let the pipeline drain fully before touching registers
    task automatic drain_pipeline();
        begin
            start <= 1'b0;
            while (pending_readings.size() != 0)
                @(negedge clk);
            repeat (LATENCY + 4) @(negedge clk);
        end
    endtask

    // present one code at a falling edge and hold it until accepted
    task automatic send_code(input logic [CODE_W-1:0] code, input bit has_known,
                             input reading_t known);
        reading_t exp_r;
        begin
            while ($urandom_range(99, 0) < send_idle_pct)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
            exp_r = convert_code(code);
            if (has_known && exp_r != known)
                $display("directed row for code %0d disagrees with predictor", code);
            start    <= 1'b1;
            adc_code <= code;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            pending_readings.push_back(has_known ? known : exp_r);
            @(negedge clk);
        end
    endtask

    // result check: every done strobe is one transaction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_readings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result temp=%0d status=%0d",
                             temp_centi_celsius, status);
            end
            else
            begin
                reading_t want;
                want = pending_readings.pop_front();
                if (want.temp !== temp_centi_celsius || want.st !== status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected temp=%0d status=%0d, got temp=%0d status=%0d",
                                 $signed(want.temp), want.st, temp_centi_celsius, status);
                end
            end
        end
    end

    // random code biased toward the ends of the range
    function automatic logic [CODE_W-1:0] pick_code();
        int sel;
        begin
            sel = $urandom_range(9, 0);
            if (sel == 0)
                return CODE_W'($urandom_range(8, 0));
            else if (sel == 1)
                return CODE_W'(4095 - $urandom_range(8, 0));
            return CODE_W'($urandom);
        end
    endfunction

    code_row_t directed_rows[$];
    reading_t  invalid_r;
    reading_t  dummy_r;

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        adc_code       = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        rf_q   = 64'(RST_FIXED_RES);
        rw_q   = 64'(RST_WIRE_RES);
        beta_q = 64'(RST_BETA);
        r0_q   = 64'(RST_NOM_RES);
        t0_q   = 64'(RST_NOM_TEMP);
        invalid_r.temp = '0;
        invalid_r.st   = ST_INVALID;
        dummy_r = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part on reset values: code zero is a non-positive resistance
        directed_rows.push_back('{code: 12'd0,    has_known: 1'b1, known: invalid_r});
        directed_rows.push_back('{code: 12'd1,    has_known: 1'b0, known: dummy_r});
        directed_rows.push_back('{code: 12'd2048, has_known: 1'b0, known: dummy_r});
        directed_rows.push_back('{code: 12'd4094, has_known: 1'b0, known: dummy_r});
        directed_rows.push_back('{code: 12'd4095, has_known: 1'b0, known: dummy_r});
        directed_rows.push_back('{code: 12'haaa,  has_known: 1'b0, known: dummy_r});
        directed_rows.push_back('{code: 12'h555,  has_known: 1'b0, known: dummy_r});
        directed_rows.push_back('{code: 12'd100,  has_known: 1'b0, known: dummy_r});
        foreach (directed_rows[i])
            send_code(directed_rows[i].code, directed_rows[i].has_known,
                      directed_rows[i].known);

        // pause until every expected result has come
        drain_pipeline();

        // zero fixed resistor: every code invalid
        write_reg(REG_FIXED_RES, 64'd0);
        send_code(12'd0,    1'b1, invalid_r);
        send_code(12'd4095, 1'b1, invalid_r);
        drain_pipeline();
        // zero nominal resistance: invalid too
        write_reg(REG_FIXED_RES, 64'd400000000);
        write_reg(REG_NOM_RES, 64'd0);
        send_code(12'd2000, 1'b1, invalid_r);
        drain_pipeline();
        // large lead resistance, tiny nominal: negative numerator and very large ratios
        write_reg(REG_NOM_RES, 64'd1);
        write_reg(REG_WIRE_RES, 64'd1000000);
        write_reg(REG_BETA, 64'd1);
        write_reg(REG_NOM_TEMP, 64'd50000);
        send_code(12'd1,    1'b0, dummy_r);
        send_code(12'd4095, 1'b0, dummy_r);
        send_code(12'd3000, 1'b0, dummy_r);
        drain_pipeline();
        // zero beta at midscale leaves a zero denominator; zero t0 gives 0 K
        write_reg(REG_WIRE_RES, 64'd0);
        write_reg(REG_NOM_RES, 64'd400000000);
        write_reg(REG_BETA, 64'd0);
        send_code(12'd2048, 1'b0, dummy_r);
        drain_pipeline();
        write_reg(REG_BETA, 64'd10000);
        write_reg(REG_NOM_TEMP, 64'd0);
        send_code(12'd2048, 1'b0, dummy_r);
        send_code(12'd4095, 1'b0, dummy_r);
        drain_pipeline();
        // index past the list is ignored
        write_reg(IDX_W'(7), 64'hffff_ffff);

        // random part: three idling phases, each with a few register settings
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 65 : 0;
            for (int s = 0; s < 4; s++)
            begin
                drain_pipeline();
                if (s == 0 && ph == 0)
                begin
                    write_reg(REG_FIXED_RES, 64'(RST_FIXED_RES));
                    write_reg(REG_WIRE_RES, 64'(RST_WIRE_RES));
                    write_reg(REG_BETA, 64'(RST_BETA));
                    write_reg(REG_NOM_RES, 64'(RST_NOM_RES));
                    write_reg(REG_NOM_TEMP, 64'(RST_NOM_TEMP));
                end
                else
                begin
                    write_reg(REG_FIXED_RES, 64'($urandom_range(400000000, 1)));
                    write_reg(REG_WIRE_RES,
                              ($urandom_range(1, 0) != 0) ? 64'($urandom_range(2000, 0))
                                                          : 64'($urandom_range(1000000, 0)));
                    write_reg(REG_BETA, 64'($urandom_range(10000, 1)));
                    write_reg(REG_NOM_RES, 64'($urandom_range(400000000, 1)));
                    write_reg(REG_NOM_TEMP, 64'($urandom_range(50000, 1)));
                end
                // an occasional full-width write exercises the register masks
                if (s == 3)
                    write_reg(IDX_W'($urandom_range(4, 0)), 64'($urandom));
                for (int n = 0; n < RAND_ITEMS / 12; n++)
                    send_code(pick_code(), 1'b0, dummy_r);
            end
        end

        drain_pipeline();
        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
